@@ design/flc_pkg.sv @@
// Shared types and constants for the full linear convolution block.
// Used by flc_front, flc_mult, flc_sum and full_linear_convolution_top.
// No dependencies.
package flc_pkg;

    // Default number of kernel taps, and the cap on results per flush
    localparam int TAPS_DEFAULT = 16;
    localparam int MAX_OUT      = 16;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int VALUE_W  = 38;
    localparam int TC_W     = 5;

    localparam logic [TC_W-1:0] TAP_COUNT_RESET = 5'd16;

    // Command codes
    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] q15_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [VALUE_W-1:0]  value_t;

    // Input transaction payload
    typedef struct packed {
        logic       cmd;
        logic [3:0] coef_index;
        q15_t       coef_value;
        q15_t       sample;
        logic       last_sample;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        value_t value;
        logic   out_last;
    } out_item_t;

endpackage

@@ design/flc_front.sv @@
// Front end: tap count register, coefficient store, delay line and tail flush
// sequencer. Emits one job (sample window plus masked coefficients) per result.
// Depends on flc_pkg.
module flc_front #(
    parameter int TAPS = flc_pkg::TAPS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [flc_pkg::TC_W-1:0]   cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  flc_pkg::in_item_t          s_data,
    output logic                       job_valid,
    input  logic                       job_ready,
    output logic                       job_last,
    output flc_pkg::q15_t              job_dl [TAPS],
    output flc_pkg::q15_t              job_cf [TAPS]
);
    import flc_pkg::*;

    localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;
    localparam int CAP   = (TAPS < MAX_OUT) ? TAPS : MAX_OUT;

    // Clamp the register to the usable tap range
    function automatic logic [TC_W-1:0] taps_in_use(input logic [TC_W-1:0] tc);
        logic [TC_W-1:0] n;
        n = tc;
        if (n == '0) begin
            n = TC_W'(1);
        end
        if (int'(n) > CAP) begin
            n = TC_W'(CAP);
        end
        return n;
    endfunction

    logic [TC_W-1:0] tap_count_reg;
    q15_t            coef_reg [TAPS];
    q15_t            dl_reg   [TAPS];
    q15_t            dl_next  [TAPS];
    logic            flush_reg, flush_next;
    logic [TC_W-1:0] remain_reg, remain_next;
    logic [TC_W-1:0] n_reg, n_next;

    logic            job_valid_reg;
    logic            job_last_reg;
    q15_t            job_dl_reg [TAPS];
    q15_t            job_cf_reg [TAPS];

    logic            job_free;
    logic            accept;
    logic            sample_acc;
    logic            coef_acc;
    logic            emit;
    logic            emit_last;
    logic [TC_W-1:0] taps_now;
    logic [TC_W-1:0] n_sel;
    logic [EXT_W-1:0] idx_ext;
    q15_t            shifted   [TAPS];
    q15_t            masked_cf [TAPS];

    assign job_free  = !job_valid_reg || job_ready;
    assign s_ready   = !flush_reg && job_free;
    assign accept    = s_valid && s_ready;
    assign idx_ext   = EXT_W'(s_data.coef_index);
    assign coef_acc  = accept && (s_data.cmd == CMD_COEF) && (int'(s_data.coef_index) < TAPS);
    assign sample_acc = accept && (s_data.cmd == CMD_SAMPLE);

    assign job_valid = job_valid_reg;
    assign job_last  = job_last_reg;
    assign job_dl    = job_dl_reg;
    assign job_cf    = job_cf_reg;

    // Next window, coefficient snapshot and flush sequencing
    always_comb begin
        taps_now = taps_in_use(tap_count_reg);
        n_sel    = flush_reg ? n_reg : taps_now;

        shifted[0] = flush_reg ? q15_t'(0) : s_data.sample;
        for (int k = 1; k < TAPS; k++) begin
            shifted[k] = dl_reg[k-1];
        end
        for (int k = 0; k < TAPS; k++) begin
            masked_cf[k] = (k < int'(n_sel)) ? coef_reg[k] : q15_t'(0);
        end

        dl_next     = dl_reg;
        flush_next  = flush_reg;
        remain_next = remain_reg;
        n_next      = n_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;

        if (flush_reg && job_free) begin
            // tail result: shift a zero in
            emit        = 1'b1;
            dl_next     = shifted;
            remain_next = remain_reg - TC_W'(1);
            if (remain_reg == TC_W'(1)) begin
                emit_last  = 1'b1;
                dl_next    = '{default: '0};
                flush_next = 1'b0;
            end
        end else if (sample_acc) begin
            emit    = 1'b1;
            dl_next = shifted;
            if (s_data.last_sample) begin
                if (taps_now == TC_W'(1)) begin
                    emit_last = 1'b1;
                    dl_next   = '{default: '0};
                end else begin
                    flush_next  = 1'b1;
                    remain_next = taps_now - TC_W'(1);
                    n_next      = taps_now;
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_RESET;
            flush_reg     <= 1'b0;
            remain_reg    <= '0;
            n_reg         <= '0;
            job_valid_reg <= 1'b0;
            dl_reg        <= '{default: '0};
            coef_reg      <= '{default: '0};
        end else begin
            if (cfg_wr_en) begin
                tap_count_reg <= cfg_wr_data;
            end
            if (coef_acc) begin
                coef_reg[idx_ext[IDX_W-1:0]] <= s_data.coef_value;
            end
            flush_reg  <= flush_next;
            remain_reg <= remain_next;
            n_reg      <= n_next;
            dl_reg     <= dl_next;
            if (job_free) begin
                job_valid_reg <= emit;
            end
        end
    end

    // Job payload
    always_ff @(posedge aclk) begin
        if (job_free && emit) begin
            job_last_reg <= emit_last;
            job_dl_reg   <= shifted;
            job_cf_reg   <= masked_cf;
        end
    end

endmodule

@@ design/flc_mult.sv @@
// Product stage: one registered 16x16 product per tap.
// Depends on flc_pkg.
module flc_mult #(
    parameter int TAPS = flc_pkg::TAPS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  logic           job_last,
    input  flc_pkg::q15_t  job_dl [TAPS],
    input  flc_pkg::q15_t  job_cf [TAPS],
    output logic           prod_valid,
    input  logic           prod_ready,
    output logic           prod_last,
    output flc_pkg::prod_t prod [TAPS]
);
    import flc_pkg::*;

    logic  prod_valid_reg;
    logic  prod_last_reg;
    prod_t prod_reg  [TAPS];
    prod_t prod_next [TAPS];

    assign job_ready  = !prod_valid_reg || prod_ready;
    assign prod_valid = prod_valid_reg;
    assign prod_last  = prod_last_reg;
    assign prod       = prod_reg;

    // Independent tap products
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            prod_next[k] = PROD_W'(job_dl[k]) * PROD_W'(job_cf[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (job_ready) begin
            prod_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) begin
            prod_last_reg <= job_last;
            prod_reg      <= prod_next;
        end
    end

endmodule

@@ design/flc_sum.sv @@
// Sum stage: balanced adder tree over the tap products into the result register.
// Depends on flc_pkg.
module flc_sum #(
    parameter int TAPS = flc_pkg::TAPS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               prod_valid,
    output logic               prod_ready,
    input  logic               prod_last,
    input  flc_pkg::prod_t     prod [TAPS],
    output logic               m_valid,
    input  logic               m_ready,
    output flc_pkg::out_item_t m_data
);
    import flc_pkg::*;

    localparam int LEVELS = (TAPS > 1) ? $clog2(TAPS) : 0;
    localparam int LEAVES = 1 << LEVELS;

    logic      m_valid_reg;
    out_item_t m_data_reg;
    value_t    tree [LEAVES];

    assign prod_ready = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Pairwise reduction, one level per pass
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            tree[i] = '0;
        end
        for (int i = 0; i < TAPS; i++) begin
            tree[i] = VALUE_W'(prod[i]);
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
                tree[i] = tree[2*i] + tree[2*i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            m_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && prod_valid) begin
            m_data_reg.value    <= tree[0];
            m_data_reg.out_last <= prod_last;
        end
    end

endmodule

@@ design/full_linear_convolution_top.sv @@
// Top level of the full linear convolution block.
// Instantiates flc_front, flc_mult and flc_sum; depends on flc_pkg.
//
// Direct-form FIR that gives the full linear convolution of a Q1.15 sample
// stream with a stored kernel of up to TAPS taps. A transaction with cmd 0
// writes one coefficient and gives no result; a transaction with cmd 1 shifts
// a sample in and gives one exact Q8.30 sum. A sample marked last is followed
// by the taps in use minus one tail results (zeros shifted in); the final one
// has out_last set and the delay line is then cleared. Transactions are taken
// one per clock while the job register is free; a last sample holds s_ready
// low while the flush sequencer issues the tail, longer when m_ready stalls.
// The job register loads at the accepting edge, then the product register
// (one multiplier per tap), then the adder tree feeds the result register that
// drives m_valid. Every stage has its own valid bit, so stalls on m_ready back
// up one stage at a time. Write tap_count only while the block is idle.
module full_linear_convolution_top #(
    parameter int TAPS = flc_pkg::TAPS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [flc_pkg::TC_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  flc_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output flc_pkg::out_item_t       m_data
);
    import flc_pkg::*;

    logic  job_valid, job_ready, job_last;
    q15_t  job_dl [TAPS];
    q15_t  job_cf [TAPS];
    logic  prod_valid, prod_ready, prod_last;
    prod_t prod [TAPS];

    flc_front #(.TAPS(TAPS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_last    (job_last),
        .job_dl      (job_dl),
        .job_cf      (job_cf)
    );

    flc_mult #(.TAPS(TAPS)) u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_last   (job_last),
        .job_dl     (job_dl),
        .job_cf     (job_cf),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_last  (prod_last),
        .prod       (prod)
    );

    flc_sum #(.TAPS(TAPS)) u_sum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_last  (prod_last),
        .prod       (prod),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for full_linear_convolution_top.
// Depends on flc_pkg and the block's RTL; predicts every result in-line
// and checks it against the result channel under random idling.
module tb_top;
    import flc_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int RESET_CYC  = 9;
    localparam int SETTLE_CYC = 8;
    localparam int RUN_LIMIT  = 3000000;
    localparam int RANDOM_PER_PHASE = 80;

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [TC_W-1:0] cfg_wr_data = '0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    in_item_t        s_data      = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    out_item_t       m_data;

    // Predictor state: kernel, delay line and tap count as the block holds them
    q15_t            kernel [TAPS_DEFAULT];
    q15_t            taps_line [TAPS_DEFAULT];
    logic [TC_W-1:0] tap_count_cfg = TAP_COUNT_RESET;

    out_item_t       conv_out_q[$];
    int              mismatch_count = 0;
    int              items_sent     = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;

    full_linear_convolution_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Model of one accepted transaction: coefficient write, or sample plus tail
    function automatic void convolve_step(in_item_t it);
        int        n;
        int        count;
        longint    acc;
        out_item_t r;
        if (it.cmd == CMD_COEF) begin
            kernel[it.coef_index] = it.coef_value;
            return;
        end
        n = int'(tap_count_cfg);
        if (n == 0) n = 1;
        if (n > TAPS_DEFAULT) n = TAPS_DEFAULT;
        if (n > MAX_OUT) n = MAX_OUT;
        count = it.last_sample ? n : 1;
        for (int t = 0; t < count; t++) begin
            for (int k = TAPS_DEFAULT - 1; k > 0; k--) taps_line[k] = taps_line[k-1];
            taps_line[0] = (t == 0) ? it.sample : q15_t'(0);
            acc = 0;
            for (int k = 0; k < n; k++) acc += longint'(kernel[k]) * longint'(taps_line[k]);
            r.value    = value_t'(acc);
            r.out_last = it.last_sample && (t == count - 1);
            conv_out_q.push_back(r);
        end
        if (it.last_sample) begin
            foreach (taps_line[k]) taps_line[k] = '0;
        end
    endfunction

    // Result checker: each result transaction against the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (conv_out_q.size() == 0) begin
                $display("%0t unexpected result: value %0d last %0b", $time,
                         $signed(m_data.value), m_data.out_last);
                mismatch_count++;
            end else begin
                want = conv_out_q.pop_front();
                if (m_data.value !== want.value) begin
                    $display("%0t value mismatch: expected %0d actual %0d", $time,
                             $signed(want.value), $signed(m_data.value));
                    mismatch_count++;
                end
                if (m_data.out_last !== want.out_last) begin
                    $display("%0t out_last mismatch: expected %0b actual %0b", $time,
                             want.out_last, m_data.out_last);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic q15_t rand_q15();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return q15_t'(16'h8000);
            1: return q15_t'(16'h7FFF);
            2: return q15_t'(16'h0000);
            3: return q15_t'(16'hFFFF);
            default: return q15_t'($urandom);
        endcase
    endfunction

    // Coefficient load; sample and last_sample carry random junk
    function automatic in_item_t coef_item(logic [3:0] idx, q15_t val);
        in_item_t it;
        it.cmd         = CMD_COEF;
        it.coef_index  = idx;
        it.coef_value  = val;
        it.sample      = q15_t'($urandom);
        it.last_sample = 1'($urandom_range(1));
        return it;
    endfunction

    // Sample push; coefficient fields carry random junk
    function automatic in_item_t sample_item(q15_t val, logic last);
        in_item_t it;
        it.cmd         = CMD_SAMPLE;
        it.coef_index  = 4'($urandom_range(15));
        it.coef_value  = q15_t'($urandom);
        it.sample      = val;
        it.last_sample = last;
        return it;
    endfunction

    // Send one input transaction, with optional idle cycles ahead of it
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        convolve_step(it);
        items_sent++;
    endtask

    // Stop sending and let every outstanding result and coefficient write land
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (conv_out_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_tap_count(logic [TC_W-1:0] v);
        drain_pipeline();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tap_count_cfg = v;
    endtask

    // Default tap count and an all-zero kernel right out of reset
    task automatic test_reset_state();
        send_item(sample_item(q15_t'(16'h7FFF), 1'b1));
    endtask

    // Full-scale coefficients and samples over the full 16-tap tail
    task automatic test_kernel_extremes();
        send_item(coef_item(4'd0,  q15_t'(16'h8000)));
        send_item(coef_item(4'd1,  q15_t'(16'h7FFF)));
        send_item(coef_item(4'd2,  q15_t'(16'hFFFF)));
        send_item(coef_item(4'd15, q15_t'(16'h8000)));
        send_item(coef_item(4'd7,  q15_t'(16'h7FFF)));
        send_item(coef_item(4'd8,  q15_t'(16'h3039)));
        send_item(sample_item(q15_t'(16'h8000), 1'b0));
        send_item(sample_item(q15_t'(16'h7FFF), 1'b0));
        send_item(sample_item(q15_t'(16'h8000), 1'b1));
    endtask

    // Zero count acts as one tap; counts past the depth saturate
    task automatic test_tap_count_limits();
        write_tap_count(5'd0);
        send_item(sample_item(q15_t'(16'h7FFF), 1'b1));
        write_tap_count(5'd31);
        send_item(sample_item(q15_t'(16'h8000), 1'b1));
        write_tap_count(5'd17);
        send_item(sample_item(q15_t'(16'h0001), 1'b1));
    endtask

    // Fields that a command does not use must have no effect
    task automatic test_ignored_fields();
        in_item_t it;
        write_tap_count(5'd4);
        it = coef_item(4'd3, q15_t'(16'h4000));
        it.sample      = q15_t'(16'hFFFF);
        it.last_sample = 1'b1;
        send_item(it);
        it = sample_item(q15_t'(16'h2000), 1'b1);
        it.coef_index = 4'hF;
        it.coef_value = q15_t'(16'h8000);
        send_item(it);
    endtask

    // New tap count takes effect mid-stream; delay line contents survive
    task automatic test_midstream_tap_change();
        write_tap_count(5'd16);
        send_item(sample_item(q15_t'(16'd100), 1'b0));
        send_item(sample_item(q15_t'(-16'sd200), 1'b0));
        write_tap_count(5'd2);
        send_item(sample_item(q15_t'(16'd300), 1'b1));
    endtask

    function automatic logic [TC_W-1:0] rand_tap_count();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return TC_W'($urandom_range(17, 31));
            default: return TC_W'($urandom_range(2, 15));
        endcase
    endfunction

    // Random sequences: mostly coefficient updates then sample bursts with a last
    task automatic test_random_streams(int idle_pct, int stall_pct);
        int       goal;
        int       pick;
        int       len;
        int       loads;
        in_item_t it;
        drain_pipeline();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_tap_count(rand_tap_count());
        goal = items_sent + RANDOM_PER_PHASE;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                write_tap_count(rand_tap_count());
            end else if (pick < 14) begin
                // noise: any command with any field content
                it.cmd         = 1'($urandom_range(1));
                it.coef_index  = 4'($urandom_range(15));
                it.coef_value  = rand_q15();
                it.sample      = rand_q15();
                it.last_sample = 1'($urandom_range(1));
                send_item(it);
            end else begin
                loads = ($urandom_range(19) == 0) ? TAPS_DEFAULT : $urandom_range(3);
                for (int i = 0; i < loads; i++) begin
                    send_item(coef_item((loads == TAPS_DEFAULT) ? i[3:0] : 4'($urandom),
                                        rand_q15()));
                end
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    // about one sequence in ten is left open
                    send_item(sample_item(rand_q15(),
                                          (i == len - 1) && ($urandom_range(9) != 0)));
                end
            end
        end
    endtask

    // Run limit
    initial begin
        #RUN_LIMIT;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        foreach (kernel[k]) kernel[k] = '0;
        foreach (taps_line[k]) taps_line[k] = '0;
        repeat (RESET_CYC) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_kernel_extremes();
        test_tap_count_limits();
        test_ignored_fields();
        test_midstream_tap_change();
        test_random_streams(0, 0);
        test_random_streams(62, 0);
        test_random_streams(0, 62);
        test_random_streams(17, 17);

        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/flc_pkg.sv
design/flc_front.sv
design/flc_mult.sv
design/flc_sum.sv
design/full_linear_convolution_top.sv
sim/tb_top.sv
